// File: design/jgec_pkg.sv
package jgec_pkg;

  localparam int unsigned MaxItems  = 1024;
  localparam int unsigned JumpBits  = 11;
  localparam int unsigned IdxW      = $clog2(MaxItems);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned CountBits = 11;

  typedef enum logic [3:0] {
    StLoad,
    StInit,
    StJoinRd,
    StJoinFind,
    StJoinLink,
    StMarkRd,
    StMarkFind,
    StSumRd,
    StSumChk,
    StOut
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic clr_list;
    logic rst_idx;
    logic inc_idx;
    logic init_wr;
    logic join_rd;
    logic find_start;
    logic link;
    logic mark;
    logic sum_chk;
    logic clr_total;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic idx_last;
    logic target_in;
    logic find_done;
    logic same_root;
  } sts_t;

endpackage

// File: design/jgec_ctrl.sv
module jgec_ctrl import jgec_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_fire_i,
  input  logic   in_last_i,
  input  logic   out_fire_i,
  input  sts_t   sts_i,
  output cmd_t   cmd_o,
  output logic   in_ready_o,
  output logic   out_valid_o
);

  state_e state_q, state_d;
  logic   second_q, second_d;

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  // Sequence the load, the passes (init, join, mark, sum) and the output.
  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.rst_idx = 1'b1;
            state_d       = StInit;
          end
        end
      end
      StInit: begin
        cmd_o.init_wr = 1'b1;
        cmd_o.inc_idx = !sts_i.idx_last;
        cmd_o.rst_idx = sts_i.idx_last;
        if (sts_i.idx_last) state_d = StJoinRd;
      end
      StJoinRd: begin
        cmd_o.join_rd = 1'b1;
        state_d       = StJoinFind;
        second_d      = 1'b0;
      end
      StJoinFind: begin
        if (!sts_i.target_in) begin
          cmd_o.inc_idx = !sts_i.idx_last;
          cmd_o.rst_idx = sts_i.idx_last;
          state_d       = sts_i.idx_last ? StMarkRd : StJoinRd;
        end else if (!second_q) begin
          cmd_o.find_start = 1'b1;
          second_d         = 1'b1;
        end else if (sts_i.find_done) begin
          state_d = StJoinLink;
        end
      end
      StJoinLink: begin
        cmd_o.link    = !sts_i.same_root;
        cmd_o.inc_idx = !sts_i.idx_last;
        cmd_o.rst_idx = sts_i.idx_last;
        state_d       = sts_i.idx_last ? StMarkRd : StJoinRd;
      end
      StMarkRd: begin
        cmd_o.join_rd = 1'b1;
        state_d       = StMarkFind;
        second_d      = 1'b0;
      end
      StMarkFind: begin
        if (sts_i.target_in) begin
          cmd_o.inc_idx = !sts_i.idx_last;
          cmd_o.rst_idx = sts_i.idx_last;
          cmd_o.clr_total = sts_i.idx_last;
          state_d       = sts_i.idx_last ? StSumRd : StMarkRd;
        end else if (!second_q) begin
          cmd_o.find_start = 1'b1;
          second_d         = 1'b1;
        end else if (sts_i.find_done) begin
          cmd_o.mark    = 1'b1;
          cmd_o.inc_idx = !sts_i.idx_last;
          cmd_o.rst_idx = sts_i.idx_last;
          cmd_o.clr_total = sts_i.idx_last;
          state_d       = sts_i.idx_last ? StSumRd : StMarkRd;
        end
      end
      StSumRd: begin
        state_d = StSumChk;
      end
      StSumChk: begin
        cmd_o.sum_chk = 1'b1;
        cmd_o.inc_idx = !sts_i.idx_last;
        state_d       = sts_i.idx_last ? StOut : StSumRd;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_fire_i) begin
          cmd_o.clr_list = 1'b1;
          state_d        = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

endmodule

// File: design/jgec_dpath.sv
module jgec_dpath import jgec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [JumpBits-1:0]   jump_i,
  output sts_t                  sts_o,
  output logic [CountBits-1:0]  good_count_o,
  output logic                  overflow_o
);

  localparam int unsigned SumW = (JumpBits > CntW ? JumpBits : CntW) + 2;

  logic [JumpBits-1:0] jump_mem [MaxItems];
  logic [IdxW-1:0]     root_mem [MaxItems];
  logic [CntW-1:0]     size_mem [MaxItems];
  logic                mark_mem [MaxItems];

  logic [CntW-1:0]      count_q;
  logic                 ovf_q;
  logic [IdxW-1:0]      idx_q;
  logic [JumpBits-1:0]  jump_rd_q;
  logic [CountBits-1:0] total_q;

  // Find unit: walks up root links, one hop a cycle.
  logic [1:0]      fphase_q;   // 0 idle, 1 find a, 2 find b
  logic [IdxW-1:0] cur_q, ra_q, rb_q, tgt_q;
  logic            fdone_q;
  logic [IdxW-1:0] cur_d, par_q;
  logic [CntW-1:0] sz_q, sa_q, sb_q;
  logic [IdxW-1:0] sum_root_q;
  logic            sum_mark_q;
  logic [CntW-1:0] sum_size_q;

  logic signed [SumW-1:0] tsum;
  logic                   tin;
  logic [IdxW-1:0]        last_idx;

  assign last_idx = IdxW'(count_q - CntW'(1));
  assign tsum = $signed({2'b0, {(SumW-2-IdxW){1'b0}}, idx_q})
              + SumW'($signed(jump_rd_q));
  assign tin  = (tsum >= 0) && (tsum < $signed(SumW'(count_q)));

  assign sts_o.idx_last  = (idx_q == last_idx);
  assign sts_o.target_in = tin;
  assign sts_o.find_done = fdone_q;
  assign sts_o.same_root = (ra_q == rb_q);

  // Track list length and overflow.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.clr_list) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (count_q < CntW'(MaxItems)) count_q <= count_q + CntW'(1);
      else ovf_q <= 1'b1;
    end
  end

  // Store jumps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < CntW'(MaxItems)) jump_mem[IdxW'(count_q)] <= jump_i;
    if (cmd_i.join_rd) jump_rd_q <= jump_mem[idx_q];
  end

  // Step the index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (cmd_i.rst_idx) idx_q <= '0;
    else if (cmd_i.inc_idx) idx_q <= idx_q + IdxW'(1);
  end

  // Find roots of index then target; no path compression is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fphase_q <= 2'd0;
      fdone_q  <= 1'b0;
    end else if (cmd_i.find_start) begin
      fphase_q <= 2'd1;
      fdone_q  <= 1'b0;
    end else if (fphase_q != 2'd0 && par_q == cur_q) begin
      if (fphase_q == 2'd1 && tin) fphase_q <= 2'd2;
      else begin
        fphase_q <= 2'd0;
        fdone_q  <= 1'b1;
      end
    end else if (cmd_i.link || cmd_i.mark) begin
      fdone_q <= 1'b0;
    end
  end

  // Pick the next walk position; its root link and size are read for the next cycle.
  always_comb begin
    cur_d = cur_q;
    if (cmd_i.find_start) cur_d = idx_q;
    else if (fphase_q != 2'd0) begin
      if (par_q != cur_q) cur_d = par_q;
      else if (fphase_q == 2'd1) cur_d = tgt_q;
    end
  end

  // Capture the roots found and their sizes.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.find_start) begin
      tgt_q <= IdxW'(tsum);
    end else if (fphase_q != 2'd0 && par_q == cur_q) begin
      if (fphase_q == 2'd1) begin
        ra_q <= cur_q;
        sa_q <= sz_q;
      end else begin
        rb_q <= cur_q;
        sb_q <= sz_q;
      end
    end
  end

  // Root, size and mark stores.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      root_mem[idx_q] <= idx_q;
      size_mem[idx_q] <= CntW'(1);
      mark_mem[idx_q] <= 1'b0;
    end else if (cmd_i.link) begin
      if (sa_q < sb_q) begin
        root_mem[ra_q] <= rb_q;
        size_mem[rb_q] <= sb_q + sa_q;
      end else begin
        root_mem[rb_q] <= ra_q;
        size_mem[ra_q] <= sa_q + sb_q;
      end
    end else if (cmd_i.mark) begin
      mark_mem[ra_q] <= 1'b1;
    end
    par_q      <= root_mem[cur_d];
    sz_q       <= size_mem[cur_d];
    sum_root_q <= root_mem[idx_q];
    sum_mark_q <= mark_mem[idx_q];
    sum_size_q <= size_mem[idx_q];
  end

  // Accumulate marked component sizes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_total) total_q <= '0;
    else if (cmd_i.sum_chk && sum_root_q == idx_q && sum_mark_q)
      total_q <= total_q + CountBits'(sum_size_q);
  end

  assign good_count_o = total_q;
  assign overflow_o   = ovf_q;

endmodule

// File: design/jump_graph_exit_count_unit.sv
// Loads one jump per cycle while loading; the result follows the last transfer of a list.
// After that transfer it runs the init, join, mark and sum passes in order; the join
// pass walks root links for each in-range target and the mark pass for each exit.
// Throughput: one item per cycle while loading, then one list at a time.
// Reset (rst_ni low, asynchronous) empties the list and clears overflow.
module jump_graph_exit_count_unit import jgec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [10:0] jump
  input  logic        s_axis_tlast,  // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [10:0] good_count
  output logic        m_axis_tuser   // overflow
);

  cmd_t cmd;
  sts_t sts;
  logic [CountBits-1:0] good_count;
  logic ovf;

  jgec_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (s_axis_tvalid && s_axis_tready),
    .in_last_i  (s_axis_tlast),
    .out_fire_i (m_axis_tvalid && m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  jgec_dpath u_dpath (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .jump_i      (s_axis_tdata[JumpBits-1:0]),
    .sts_o       (sts),
    .good_count_o(good_count),
    .overflow_o  (ovf)
  );

  assign m_axis_tdata = {{(16-CountBits){1'b0}}, good_count};
  assign m_axis_tuser = ovf;

endmodule

// File: design/jgec_checker.sv
module jgec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Never take input while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during result");

  // Result stays until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  // Count never exceeds capacity.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 16'd1024) else $error("count out of range");

endmodule

bind jump_graph_exit_count_unit jgec_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
